>>> sv/mfp_pkg.sv
// Shared types, constants and the CRC8 DVB-S2 step function for the MSP v2 frame parser.
package mfp_pkg;

	localparam logic [7:0] CRC_POLY     = 8'hD5;
	localparam logic [7:0] CRC_TOPBIT   = 8'h80;
	localparam logic [7:0] HEADER_RESET = 8'h24;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_OK      = 2'd1,
		KIND_BAD_CRC = 2'd2,
		KIND_REJECT  = 2'd3
	} mfp_kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       first_byte;
	} mfp_item_t;

	typedef struct packed {
		mfp_kind_t   kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [7:0]  frame_flags;
		logic [15:0] function_id;
		logic [15:0] payload_size;
		logic [7:0]  crc_value;
	} mfp_result_t;

	// Control between the stages: what the parser would emit for the held byte.
	typedef struct packed {
		logic        has_res;
		mfp_result_t res;
	} mfp_step_t;

	// One byte through CRC8 DVB-S2, MSB first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOPBIT) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/mfp_rx_if.sv
// Received byte channel: valid, ready and one byte with its buffer-start mark.
interface mfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       first_byte;

	modport source (output valid, output rx_byte, output first_byte, input ready);
	modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

>>> sv/mfp_res_if.sv
// Result channel: valid, ready and one parser result item.
interface mfp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  frame_flags;
	logic [15:0] function_id;
	logic [15:0] payload_size;
	logic [7:0]  crc_value;

	modport source (output valid, output kind, output payload_byte, output payload_index,
		output frame_flags, output function_id, output payload_size, output crc_value,
		input ready);
	modport sink   (input valid, input kind, input payload_byte, input payload_index,
		input frame_flags, input function_id, input payload_size, input crc_value,
		output ready);
endinterface

>>> sv/mfp_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module mfp_in_stage import mfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mfp_item_t in_item,
	input  logic      advance,
	output logic      valid_s1,
	output mfp_item_t item_s1
);

	logic v_s1;

	assign in_ready = !v_s1 || advance;
	assign valid_s1 = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> sv/mfp_parser.sv
// Frame state machine, held header fields and running CRC; one byte per fire.
module mfp_parser import mfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  mfp_item_t  item,
	input  logic       fire,
	output mfp_step_t  step
);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_SKIP1   = 10'b0000000010,
		ST_SKIP2   = 10'b0000000100,
		ST_FLAGS   = 10'b0000001000,
		ST_ID_LO   = 10'b0000010000,
		ST_ID_HI   = 10'b0000100000,
		ST_SIZE_LO = 10'b0001000000,
		ST_SIZE_HI = 10'b0010000000,
		ST_PAYLOAD = 10'b0100000000,
		ST_CRC     = 10'b1000000000
	} mfp_state_t;

	mfp_state_t  state_q, state_d;
	logic [7:0]  header_q;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  flags_q, flags_d;
	logic [15:0] func_q, func_d;
	logic [15:0] size_q, size_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  crc_new;
	logic [15:0] count_inc;

	assign crc_new   = crc8_step(crc_q, item.rx_byte);
	assign count_inc = count_q + 16'd1;

	always_comb begin
		state_d  = state_q;
		crc_d    = crc_q;
		flags_d  = flags_q;
		func_d   = func_q;
		size_d   = size_q;
		count_d  = count_q;
		step     = '0;
		if (item.first_byte) begin
			crc_d   = 8'h00;
			flags_d = 8'h00;
			func_d  = 16'h0000;
			size_d  = 16'h0000;
			count_d = 16'h0000;
			if (item.rx_byte != header_q) begin
				step.has_res  = 1'b1;
				step.res.kind = KIND_REJECT;
				state_d       = ST_IDLE;
			end else begin
				state_d = ST_SKIP1;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_d = ST_IDLE;
				end
				ST_SKIP1: begin
					state_d = ST_SKIP2;
				end
				ST_SKIP2: begin
					state_d = ST_FLAGS;
				end
				ST_FLAGS: begin
					flags_d = item.rx_byte;
					crc_d   = crc_new;
					state_d = ST_ID_LO;
				end
				ST_ID_LO: begin
					func_d  = {8'h00, item.rx_byte};
					crc_d   = crc_new;
					state_d = ST_ID_HI;
				end
				ST_ID_HI: begin
					func_d  = {item.rx_byte, func_q[7:0]};
					crc_d   = crc_new;
					state_d = ST_SIZE_LO;
				end
				ST_SIZE_LO: begin
					size_d  = {8'h00, item.rx_byte};
					crc_d   = crc_new;
					state_d = ST_SIZE_HI;
				end
				ST_SIZE_HI: begin
					size_d  = {item.rx_byte, size_q[7:0]};
					crc_d   = crc_new;
					count_d = 16'h0000;
					state_d = ({item.rx_byte, size_q[7:0]} == 16'h0000) ? ST_CRC : ST_PAYLOAD;
				end
				ST_PAYLOAD: begin
					crc_d                   = crc_new;
					count_d                 = count_inc;
					step.has_res            = 1'b1;
					step.res.kind           = KIND_PAYLOAD;
					step.res.payload_byte   = item.rx_byte;
					step.res.payload_index  = count_q;
					step.res.frame_flags    = flags_q;
					step.res.function_id    = func_q;
					step.res.payload_size   = size_q;
					step.res.crc_value      = crc_new;
					state_d = (count_inc == size_q) ? ST_CRC : ST_PAYLOAD;
				end
				ST_CRC: begin
					step.has_res          = 1'b1;
					step.res.kind         = (crc_q == item.rx_byte) ? KIND_OK : KIND_BAD_CRC;
					step.res.frame_flags  = flags_q;
					step.res.function_id  = func_q;
					step.res.payload_size = size_q;
					step.res.crc_value    = crc_q;
					state_d               = ST_IDLE;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			crc_q   <= 8'h00;
			flags_q <= 8'h00;
			func_q  <= 16'h0000;
			size_q  <= 16'h0000;
			count_q <= 16'h0000;
		end else if (fire) begin
			state_q <= state_d;
			crc_q   <= crc_d;
			flags_q <= flags_d;
			func_q  <= func_d;
			size_q  <= size_d;
			count_q <= count_d;
		end
	end

	a_header_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.first_byte && (item.rx_byte == header_q) |=> state_q == ST_SKIP1)
		else $error("matching header did not start a frame");

	a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		step.has_res && (step.res.kind == KIND_PAYLOAD) |-> state_q == ST_PAYLOAD)
		else $error("payload result outside payload phase");

	a_count_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAYLOAD |-> count_q != size_q)
		else $error("payload count reached size without leaving payload phase");

endmodule

>>> sv/mfp_out_stage.sv
// Result register: holds one result item until the sink takes it.
module mfp_out_stage import mfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  mfp_result_t push_res,
	output logic        can_load,
	output logic        out_valid,
	input  logic        out_ready,
	output mfp_result_t out_res
);

	logic out_v_q;

	assign can_load  = !out_v_q || out_ready;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (can_load) begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_load) begin
			out_res <= push_res;
		end
	end

endmodule

>>> sv/msp_v2_frame_parser.sv
// Top level of the MSP v2 frame parser with CRC8 DVB-S2 check.
//
//   channel | direction | transfer carries
//   --------+-----------+-------------------------------------------------------
//   rx      | sink      | rx_byte, first_byte
//   res     | source    | kind, payload_byte, payload_index, frame_flags,
//           |           | function_id, payload_size, crc_value
//   cfg     | write     | cfg_wdata -> header_byte (no index, no read-back)
//
// One byte per cycle unless a byte with a result meets a full result register; a byte
// taken at an rx transfer is held in the input register, and its result, if any, is
// loaded into the result register as the byte advances, raising res valid. The payload
// counter increment and size compare, beside the per-byte CRC update (a linear XOR
// network a few levels deep), set the path between those registers.
// Reset clears the frame state, the valid bits and sets header_byte to 0x24.
// A stalled res sink holds a byte in the input register only when it produces a
// result; bytes without a result keep flowing while a result waits.
module msp_v2_frame_parser import mfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mfp_rx_if.sink     rx,
	mfp_res_if.source  res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	mfp_item_t   in_item;
	mfp_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        push;
	logic        can_load;
	mfp_step_t   step;
	mfp_result_t out_res;

	assign in_item.rx_byte    = rx.rx_byte;
	assign in_item.first_byte = rx.first_byte;

	// Advance the held byte unless it has a result and the result register is full.
	assign advance = valid_s1 && (!step.has_res || can_load);
	assign push    = advance && step.has_res;

	mfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mfp_parser u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.fire      (advance),
		.step      (step)
	);

	mfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (step.res),
		.can_load  (can_load),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_res   (out_res)
	);

	assign res.kind          = out_res.kind;
	assign res.payload_byte  = out_res.payload_byte;
	assign res.payload_index = out_res.payload_index;
	assign res.frame_flags   = out_res.frame_flags;
	assign res.function_id   = out_res.function_id;
	assign res.payload_size  = out_res.payload_size;
	assign res.crc_value     = out_res.crc_value;

	// A new result never lands on one that the sink has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!res.valid || res.ready))
		else $error("result register overwritten while full");

	// A pushed result is visible on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> res.valid)
		else $error("pushed result not presented");

	// A held byte with no result never waits on the output side.
	a_no_res_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step.has_res |-> advance)
		else $error("byte without result stalled");

endmodule
